### rtl/arm_pkg.sv
// arm_pkg: shared types and constants for the address range run merger.
// Used by every module under rtl/; depends on nothing.

package arm_pkg;

	localparam int PARTS_MAX     = 8;  // 16-bit parts carried by the 128-bit fields
	localparam int V4_PARTS      = 4;
	localparam int MAX_PARTS_DEF = 8;
	localparam int MID_DEPTH_DEF = 2;
	localparam int RES_DEPTH     = 4;  // result queue, room for two results per item

	typedef logic [PARTS_MAX-1:0][15:0] part_vec_t;

	typedef struct packed {
		logic        is_ipv6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [63:0] span_high;
		logic [63:0] span_low;
		logic        last_in_list;
	} arm_req_t;

	typedef struct packed {
		logic        out_is_ipv6;
		logic [63:0] out_addr_high;
		logic [63:0] out_addr_low;
		logic [63:0] out_span_high;
		logic [63:0] out_span_low;
		logic        final_range;
		logic        any_merged;
	} arm_res_t;

	// request after unpacking: one 16-bit start and span per part
	typedef struct packed {
		logic                 is_ipv6;
		logic                 last;
		logic [PARTS_MAX-1:0] act;   // parts that take part in the compare
		part_vec_t            part;
		part_vec_t            span;
	} arm_item_t;

endpackage

### rtl/address_range_run_merger.sv
// address_range_run_merger: top level, front end -> request queue -> merge engine.
// Depends on arm_pkg, arm_front, arm_fifo, arm_back.
//
//   channel   handshake          payload              per request
//   request   push / full        arm_pkg::arm_req_t   one range in
//   result    empty / pop        arm_pkg::arm_res_t   zero, one or two ranges out
//
// One request per cycle sustained while the result queue keeps two free slots; a
// request whose results are two (an unmerged last range) needs two pops to drain.
// After a request is accepted, the front register loads at the accepting edge, then
// the request queue, and then the merge engine writes the result queue, whose head
// is on the result ports.
// The merge engine takes a request only with two free result queue slots.
// Reset clears all control state; no clearing pass, held parts are written
// before they are read.

module address_range_run_merger #(
	parameter int MAX_PARTS = arm_pkg::MAX_PARTS_DEF,
	parameter int MID_DEPTH = arm_pkg::MID_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  arm_pkg::arm_req_t request,
	output logic              empty,
	input  logic              pop,
	output arm_pkg::arm_res_t result
);

	localparam int ITEM_W = $bits(arm_pkg::arm_item_t);

	logic               mid_push, mid_full, mid_pop, mid_empty;
	arm_pkg::arm_item_t mid_in, mid_out;
	logic [ITEM_W-1:0]  mid_rdata;

	arm_front #(.MAX_PARTS(MAX_PARTS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.q_full (mid_full),
		.q_push (mid_push),
		.q_item (mid_in)
	);

	arm_fifo #(.WIDTH(ITEM_W), .DEPTH(MID_DEPTH)) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_in),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	assign mid_out = arm_pkg::arm_item_t'(mid_rdata);

	arm_back #(.MAX_PARTS(MAX_PARTS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(mid_empty),
		.q_item (mid_out),
		.q_pop  (mid_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

### rtl/arm_fifo.sv
// arm_fifo: small first-in first-out queue between the front and back ends.
// Generic over width and depth; depends on arm_pkg for the default depth.

module arm_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = arm_pkg::MID_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/arm_front.sv
// arm_front: takes requests, splits start and span into parts and marks
// the parts that count for the family. Depends on arm_pkg.

module arm_front #(
	parameter int MAX_PARTS = arm_pkg::MAX_PARTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  arm_pkg::arm_req_t   request,
	input  logic                q_full,
	output logic                q_push,
	output arm_pkg::arm_item_t  q_item
);

	logic               valid_s1;
	arm_pkg::arm_item_t item_s1;
	arm_pkg::arm_item_t item_d;
	logic               advance;

	// stage empties into the queue or is empty already
	assign advance = !valid_s1 || !q_full;
	assign full    = !advance;
	assign q_push  = valid_s1;
	assign q_item  = item_s1;

	always_comb begin
		item_d         = '0;
		item_d.is_ipv6 = request.is_ipv6;
		item_d.last    = request.last_in_list;
		for (int k = 0; k < arm_pkg::PARTS_MAX; k++) begin
			if ((request.is_ipv6 && k < MAX_PARTS) ||
			    (!request.is_ipv6 && k < arm_pkg::V4_PARTS)) begin
				item_d.act[k] = 1'b1;
				if (k < 4) begin
					item_d.span[k] = request.span_high[63-16*(k%4) -: 16];
				end else begin
					item_d.span[k] = request.span_low[63-16*(k%4) -: 16];
				end
				if (!request.is_ipv6) begin
					item_d.part[k] = {8'h00, request.addr_low[31-8*(k%4) -: 8]};
				end else if (k < 4) begin
					item_d.part[k] = request.addr_high[63-16*(k%4) -: 16];
				end else begin
					item_d.part[k] = request.addr_low[63-16*(k%4) -: 16];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && advance) begin
			item_s1 <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

endmodule

### rtl/arm_back.sv
// arm_back: merge engine holding the current range, plus the result queue.
// Depends on arm_pkg.

module arm_back #(
	parameter int MAX_PARTS = arm_pkg::MAX_PARTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  arm_pkg::arm_item_t q_item,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output arm_pkg::arm_res_t  result
);

	localparam int RES_AW = $clog2(arm_pkg::RES_DEPTH);
	localparam int RES_CW = $clog2(arm_pkg::RES_DEPTH + 1);

	logic                 holding_q, held_v6_q, merge_seen_q;
	logic [15:0]          held_part_q [MAX_PARTS];
	logic [15:0]          held_span_q [MAX_PARTS];
	arm_pkg::part_vec_t   hp, hs, np, ns;
	logic [arm_pkg::PARTS_MAX-1:0] adj;
	logic                 bad, merge, emit_old, take;
	arm_pkg::arm_res_t    res_old, res_last, wr0;
	logic [1:0]           n_wr;

	arm_pkg::arm_res_t    res_q [arm_pkg::RES_DEPTH];
	logic [RES_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [RES_CW-1:0]    count_q;
	logic                 do_pop;

	function automatic arm_pkg::arm_res_t pack_range(input logic v6,
			input arm_pkg::part_vec_t p, input arm_pkg::part_vec_t s,
			input logic fin, input logic merged);
		arm_pkg::arm_res_t r;
		r             = '0;
		r.out_is_ipv6 = v6;
		for (int k = 0; k < 4; k++) begin
			r.out_span_high[63-16*k -: 16] = s[k];
			r.out_span_low[63-16*k -: 16]  = s[k+4];
			if (v6) begin
				r.out_addr_high[63-16*k -: 16] = p[k];
				r.out_addr_low[63-16*k -: 16]  = p[k+4];
			end else begin
				r.out_addr_low[31-8*k -: 8] = p[k][7:0];
			end
		end
		r.final_range = fin;
		r.any_merged  = fin && merged;
		return r;
	endfunction

	// fixed-width views of the held range; parts past MAX_PARTS read as zero
	for (genvar g = 0; g < arm_pkg::PARTS_MAX; g++) begin : g_view
		if (g < MAX_PARTS) begin : g_live
			assign hp[g] = held_part_q[g];
			assign hs[g] = held_span_q[g];
		end else begin : g_zero
			assign hp[g] = '0;
			assign hs[g] = '0;
		end
	end

	// per-part adjacency and equality, all parts side by side
	always_comb begin
		logic [16:0] end17, sum17;
		bad = 1'b0;
		adj = '0;
		ns  = hs;
		for (int k = 0; k < arm_pkg::PARTS_MAX; k++) begin
			end17  = {1'b0, hp[k]} + {1'b0, hs[k]} + 17'd1;
			sum17  = {1'b0, hs[k]} + {1'b0, q_item.span[k]} + 17'd1;
			adj[k] = q_item.act[k] && (end17 == {1'b0, q_item.part[k]});
			if (q_item.act[k] && !adj[k] &&
			    (hp[k] != q_item.part[k] || hs[k] != q_item.span[k])) begin
				bad = 1'b1;
			end
			if (adj[k]) begin
				ns[k] = sum17[16] ? 16'hFFFF : sum17[15:0];
			end
		end
	end

	assign merge    = holding_q && (q_item.is_ipv6 == held_v6_q) && !bad &&
	                  (adj != '0) && ((adj & (adj - 8'd1)) == '0);
	assign emit_old = holding_q && !merge;
	assign np       = merge ? hp : q_item.part;

	assign res_old  = pack_range(held_v6_q, hp, hs, 1'b0, 1'b0);
	assign res_last = pack_range(merge ? held_v6_q : q_item.is_ipv6, np,
	                             merge ? ns : q_item.span, 1'b1, merge_seen_q || merge);
	assign wr0      = emit_old ? res_old : res_last;
	assign n_wr     = {1'b0, emit_old} + {1'b0, q_item.last};

	// only take a request when two result slots are free
	assign take   = !q_empty && (count_q <= RES_CW'(arm_pkg::RES_DEPTH - 2));
	assign q_pop  = take;
	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign result = res_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < MAX_PARTS; k++) begin
				held_part_q[k] <= np[k];
				held_span_q[k] <= merge ? ns[k] : q_item.span[k];
			end
			if (n_wr != 2'd0) begin
				res_q[wr_ptr_q] <= wr0;
			end
			if (n_wr == 2'd2) begin
				res_q[wr_ptr_q + RES_AW'(1)] <= res_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q    <= 1'b0;
			held_v6_q    <= 1'b0;
			merge_seen_q <= 1'b0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
		end else begin
			if (take) begin
				holding_q    <= !q_item.last;
				held_v6_q    <= merge ? held_v6_q : q_item.is_ipv6;
				merge_seen_q <= !q_item.last && (merge_seen_q || merge);
				wr_ptr_q     <= wr_ptr_q + RES_AW'(n_wr);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			end
			count_q <= count_q + RES_CW'(take ? n_wr : 2'd0) - RES_CW'(do_pop);
		end
	end

endmodule

### rtl/arm_checker.sv
// arm_checker: port-level checks on the range merger, bound to the top level.
// Depends on arm_pkg and address_range_run_merger.

module arm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input arm_pkg::arm_req_t request,
	input logic              empty,
	input logic              pop,
	input arm_pkg::arm_res_t result
);

	// nothing can be waiting right after reset
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result queue not empty after reset");

	// merge flag only rides on the final range of a list
	a_merged_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.final_range) |-> !result.any_merged)
		else $error("any_merged set on a non-final range");

	// IPv4 ranges never carry bits outside the four address bytes and four span parts
	a_v4_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.out_is_ipv6) |->
			(result.out_addr_high == '0 && result.out_addr_low[63:32] == '0 &&
			 result.out_span_low == '0))
		else $error("IPv4 result has bits outside its parts");

	// a waiting result holds until popped
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before pop");

endmodule

bind address_range_run_merger arm_checker u_arm_checker (.*);

### tb/sv/address_range_run_merger_test.sv
// address_range_run_merger_test: self-checking bench for the range merger, driving
// push/full requests and popping empty/pop results against a built-in merge predictor.
// Depends on arm_pkg and address_range_run_merger.

module address_range_run_merger_test;

	typedef arm_pkg::arm_req_t  arm_req_t;
	typedef arm_pkg::arm_res_t  arm_res_t;
	typedef arm_pkg::part_vec_t part_vec_t;

	localparam int PARTS       = arm_pkg::MAX_PARTS_DEF;
	localparam int V4_PARTS    = arm_pkg::V4_PARTS;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 165;

	typedef struct packed {
		arm_req_t req;
		logic     typed;
		arm_res_t want;
	} plan_row_t;

	localparam arm_res_t NO_RESULT = '0;

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	arm_req_t request;
	logic     empty;
	logic     pop;
	arm_res_t result;

	// predictor copy of the held range
	logic      run_open;
	logic      run_v6;
	part_vec_t run_start;
	part_vec_t run_span;
	logic      run_merged;

	arm_res_t  pending_ranges[$];
	arm_res_t  oldest;
	plan_row_t plan[$];
	int        mismatches  = 0;
	int        items_sent  = 0;
	int        idle_pct    = 0;
	int        stall_pct   = 0;
	int        cycle_count = 0;

	address_range_run_merger i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] pick_span(bit v6);
		if ($urandom_range(7) == 0)
			return 16'($urandom);
		return 16'($urandom_range(v6 ? 15 : 3));
	endfunction

	function automatic void split_range(input arm_req_t r, output part_vec_t st,
			output part_vec_t sp);
		int n;
		n = r.is_ipv6 ? PARTS : V4_PARTS;
		st = '0;
		sp = '0;
		for (int k = 0; k < n; k++) begin
			if (r.is_ipv6)
				st[k] = (k < 4) ? r.addr_high[63-16*k -: 16] : r.addr_low[127-16*k -: 16];
			else
				st[k] = {8'h00, r.addr_low[31-8*k -: 8]};
			sp[k] = (k < 4) ? r.span_high[63-16*k -: 16] : r.span_low[127-16*k -: 16];
		end
	endfunction

	function automatic arm_req_t pack_range(bit v6, part_vec_t st, part_vec_t sp, bit last);
		arm_req_t r;
		r = '0;
		// fields an IPv4 request ignores get junk half the time
		if (!v6 && $urandom_range(1)) begin
			r.addr_high = rand64();
			r.addr_low  = rand64();
			r.span_low  = rand64();
		end
		r.is_ipv6      = v6;
		r.last_in_list = last;
		for (int k = 0; k < PARTS; k++) begin
			if (v6) begin
				if (k < 4)
					r.addr_high[63-16*k -: 16] = st[k];
				else
					r.addr_low[127-16*k -: 16] = st[k];
			end else if (k < V4_PARTS) begin
				r.addr_low[31-8*k -: 8] = st[k][7:0];
			end
			if (v6 || k < V4_PARTS) begin
				if (k < 4)
					r.span_high[63-16*k -: 16] = sp[k];
				else
					r.span_low[127-16*k -: 16] = sp[k];
			end
		end
		return r;
	endfunction

	function automatic arm_req_t noise_range(bit last);
		arm_req_t r;
		r.is_ipv6      = 1'($urandom_range(1));
		r.addr_high    = rand64();
		r.addr_low     = rand64();
		r.span_high    = rand64();
		r.span_low     = rand64();
		r.last_in_list = last;
		return r;
	endfunction

	function automatic arm_req_t fresh_range(bit v6, bit last);
		part_vec_t   st;
		part_vec_t   sp;
		int          n;
		logic [15:0] top;
		st  = '0;
		sp  = '0;
		n   = v6 ? PARTS : V4_PARTS;
		top = v6 ? 16'hFFFF : 16'h00FF;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(7) == 0)
				st[k] = top - 16'($urandom_range(3));
			else
				st[k] = 16'($urandom_range(top));
			sp[k] = pick_span(v6);
		end
		return pack_range(v6, st, sp, last);
	endfunction

	// next range that continues the held one in one part; broken ones spoil the match
	function automatic arm_req_t grow_range(bit last, bit broken);
		part_vec_t st;
		part_vec_t sp;
		bit        v6;
		int        n;
		int        k;
		int        j;
		st = run_start;
		sp = run_span;
		v6 = run_v6;
		n  = v6 ? PARTS : V4_PARTS;
		k  = $urandom_range(n - 1);
		j  = (k + 1 + $urandom_range(n - 2)) % n;
		st[k] = run_start[k] + run_span[k] + 16'd1;
		sp[k] = pick_span(v6);
		if (broken) begin
			case ($urandom_range(3))
				0: st[j] = st[j] + 16'd1;
				1: sp[j] = sp[j] ^ 16'h0001;
				2: v6 = !v6;
				default: st[j] = run_start[j] + run_span[j] + 16'd1;
			endcase
		end
		return pack_range(v6, st, sp, last);
	endfunction

	function automatic arm_res_t held_as_result(bit fin);
		arm_res_t o;
		int       n;
		o = '0;
		o.out_is_ipv6 = run_v6;
		n = run_v6 ? PARTS : V4_PARTS;
		for (int k = 0; k < n; k++) begin
			if (k < 4)
				o.out_span_high[63-16*k -: 16] = run_span[k];
			else
				o.out_span_low[127-16*k -: 16] = run_span[k];
			if (!run_v6)
				o.out_addr_low[31-8*k -: 8] = run_start[k][7:0];
			else if (k < 4)
				o.out_addr_high[63-16*k -: 16] = run_start[k];
			else
				o.out_addr_low[127-16*k -: 16] = run_start[k];
		end
		o.final_range = fin;
		o.any_merged  = fin && run_merged;
		return o;
	endfunction

	// part where the request extends the held range, -1 when it cannot merge
	function automatic int adjacent_part(bit v6, part_vec_t st, part_vec_t sp);
		int n;
		int hits;
		int at;
		int reach;
		if (v6 != run_v6)
			return -1;
		n    = v6 ? PARTS : V4_PARTS;
		hits = 0;
		at   = 0;
		for (int k = 0; k < n; k++) begin
			reach = int'(run_start[k]) + int'(run_span[k]) + 1;  // no wrap
			if (reach == int'(st[k])) begin
				hits++;
				at = k;
			end else if (run_start[k] != st[k] || run_span[k] != sp[k]) begin
				return -1;
			end
		end
		return (hits == 1) ? at : -1;
	endfunction

	task automatic predict_merge(input arm_req_t r, input bit keep);
		part_vec_t st;
		part_vec_t sp;
		int        at;
		int        sum;
		split_range(r, st, sp);
		at = run_open ? adjacent_part(r.is_ipv6, st, sp) : -1;
		if (at >= 0) begin
			sum = int'(run_span[at]) + int'(sp[at]) + 1;
			run_span[at] = (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
			run_merged = 1'b1;
		end else begin
			if (run_open && keep)
				pending_ranges.push_back(held_as_result(1'b0));
			run_v6    = r.is_ipv6;
			run_start = st;
			run_span  = sp;
			run_open  = 1'b1;
		end
		if (r.last_in_list) begin
			if (keep)
				pending_ranges.push_back(held_as_result(1'b1));
			run_open   = 1'b0;
			run_merged = 1'b0;
		end
	endtask

	// starts and ends at a falling edge; push stays high into the next call
	task automatic offer(input arm_req_t r, input bit typed, input arm_res_t want);
		while ($urandom_range(99) < idle_pct) begin
			push    <= 1'b0;
			request <= noise_range(1'($urandom_range(1)));
			@(negedge clk);
		end
		push    <= 1'b1;
		request <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_merge(r, !typed);
		if (typed)
			pending_ranges.push_back(want);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_list(input int len);
		arm_req_t r;
		bit       fam;
		bit       last;
		int       roll;
		fam = 1'($urandom_range(1));
		for (int i = 0; i < len; i++) begin
			last = (i == len - 1);
			roll = $urandom_range(99);
			if (run_open && roll < 70)
				r = grow_range(last, 1'b0);
			else if (run_open && roll < 82)
				r = grow_range(last, 1'b1);
			else if (roll < 92)
				r = fresh_range(($urandom_range(9) == 0) ? !fam : fam, last);
			else
				r = noise_range(last);
			offer(r, 1'b0, NO_RESULT);
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
		end
	endfunction

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_ranges.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing pending, expected none got %h",
					$time, result);
			end else begin
				oldest = pending_ranges.pop_front();
				check_field("out_is_ipv6", oldest.out_is_ipv6, result.out_is_ipv6);
				check_field("out_addr_high", oldest.out_addr_high, result.out_addr_high);
				check_field("out_addr_low", oldest.out_addr_low, result.out_addr_low);
				check_field("out_span_high", oldest.out_span_high, result.out_span_high);
				check_field("out_span_low", oldest.out_span_low, result.out_span_low);
				check_field("final_range", oldest.final_range, result.final_range);
				check_field("any_merged", oldest.any_merged, result.any_merged);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int target;
		arst_n     = 1'b0;
		push       = 1'b0;
		request    = '0;
		run_open   = 1'b0;
		run_v6     = 1'b0;
		run_merged = 1'b0;
		run_start  = '0;
		run_span   = '0;

		// lone last ranges at the extremes, ignored IPv4 bits full of junk
		plan.push_back('{arm_req_t'{1'b0, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hC3C3_3C3C_9999_6666, 1'b1}, 1'b1,
			arm_res_t'{1'b0, 64'h0, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0, 1'b1, 1'b0}});
		plan.push_back('{arm_req_t'{1'b1, '1, '1, '1, '1, 1'b1}, 1'b1,
			arm_res_t'{1'b1, '1, '1, '1, '1, 1'b1, 1'b0}});
		plan.push_back('{arm_req_t'{1'b1, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1}, 1'b1,
			arm_res_t'{1'b1, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b0}});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1}, 1'b1,
			arm_res_t'{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b0}});
		// IPv4 run of three, then a duplicate and a family change
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'h0A00_0000, 64'h0, 64'h0, 1'b0}, 1'b0,
			NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'hFFFF_FFFF_0A00_0100, 64'h0, 64'h0, 1'b0},
			1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'h0A00_0200, 64'h0, 64'h0, 1'b0}, 1'b0,
			NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'h0A00_0200, 64'h0, 64'h0, 1'b0}, 1'b0,
			NO_RESULT});
		plan.push_back('{arm_req_t'{1'b1, 64'h2001_0DB8_0000_0000, 64'h0, 64'h0, 64'h0, 1'b0},
			1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b1, 64'h2001_0DB8_0000_0000, 64'h1, 64'h0, 64'h0, 1'b1},
			1'b0, NO_RESULT});
		// span saturation, exact duplicate, no wrap at the top of a part
		plan.push_back('{arm_req_t'{1'b1, 64'h0, 64'h0, 64'hFFF0_0000_0000_0000, 64'h0, 1'b0},
			1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b1, 64'hFFF1_0000_0000_0000, 64'h0,
			64'h00FF_0000_0000_0000, 64'h0, 1'b0}, 1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b1, 64'h0, 64'h0, 64'hFFFF_0000_0000_0000, 64'h0, 1'b0},
			1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b1, 64'hFF00_0000_0000_0000, 64'h0,
			64'h00FF_0000_0000_0000, 64'h0, 1'b0}, 1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b1, 64'h0, 64'h0, 64'h00FF_0000_0000_0000, 64'h0, 1'b0},
			1'b0, NO_RESULT});
		// two adjacent parts at once, then an unmerged last range
		plan.push_back('{arm_req_t'{1'b1, 64'h0100_0001_0000_0000, 64'h0,
			64'h00FF_0000_0000_0000, 64'h0, 1'b0}, 1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'hC0A8_0000, 64'h0, 64'h0, 1'b1}, 1'b0,
			NO_RESULT});
		// IPv4 spans wider than a byte
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'h1000_0000, 64'h000F_0000_0000_0000, 64'h0,
			1'b0}, 1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'h2000_0000, 64'h0010_0000_0000_0000, 64'h0,
			1'b0}, 1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'hF000_0000, 64'h000F_0000_0000_0000, 64'h0,
			1'b0}, 1'b0, NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h0, 64'h0000_0000, 64'h000F_0000_0000_0000, 64'h0,
			1'b1}, 1'b0, NO_RESULT});
		// merge while ignored IPv4 fields differ
		plan.push_back('{arm_req_t'{1'b0, 64'h1111, 64'h0102_0304, 64'h0, 64'h1234, 1'b0}, 1'b0,
			NO_RESULT});
		plan.push_back('{arm_req_t'{1'b0, 64'h2222, 64'h0102_0305, 64'h0, 64'h9876, 1'b1}, 1'b0,
			NO_RESULT});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			offer(plan[i].req, plan[i].typed, plan[i].want);

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				send_list(($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6));
		end

		push      <= 1'b0;
		request   <= '0;
		stall_pct = 0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		// anything trailing would show up as unexpected
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
rtl/arm_pkg.sv
rtl/arm_fifo.sv
rtl/arm_front.sv
rtl/arm_back.sv
rtl/address_range_run_merger.sv
rtl/arm_checker.sv
tb/sv/address_range_run_merger_test.sv
